[hw/rtl/ptta_pkg.sv]
// ----------------------------------------------------------------------------
// ptta_pkg
// Types and constants shared by the peer table: transaction structs, entry
// layout, operation and status codes.
// ----------------------------------------------------------------------------
package ptta_pkg;

    localparam int PEER_SLOTS   = 512;
    localparam int PAYLOAD_BITS = 64;
    localparam int SLOT_W       = $clog2(PEER_SLOTS);
    localparam int FREED_W      = $clog2(PEER_SLOTS + 1);

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_AGED      = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] peer_address;
        logic [63:0] peer_payload;
        logic [8:0]  read_slot;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  slot_used;
        logic [9:0]  expired_count;
        logic        entry_valid;
        logic [31:0] entry_address;
        logic [63:0] entry_payload;
        logic [7:0]  entry_ttl;
    } rsp_t;

    typedef struct packed {
        logic                    valid;
        logic [31:0]             address;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [7:0]              ttl;
    } entry_t;

    typedef struct packed {
        logic              shift_en;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
    } ring_ctl_t;

endpackage

[hw/rtl/ptta_cell.sv]
// ----------------------------------------------------------------------------
// ptta_cell
// One table entry; shifts to its neighbor during a walk or takes a write.
// ----------------------------------------------------------------------------
module ptta_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  logic            wr_en,
    input  ptta_pkg::entry_t shift_in,
    input  ptta_pkg::entry_t wr_data,
    output ptta_pkg::entry_t q
);
    import ptta_pkg::*;

    logic                    valid_reg;
    logic [31:0]             address_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [7:0]              ttl_reg;
    entry_t                  entry_next;

    always_comb
    begin
        if (wr_en)
        begin
            entry_next = wr_data;
        end
        else if (shift_en)
        begin
            entry_next = shift_in;
        end
        else
        begin
            entry_next = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        address_reg <= entry_next.address;
        payload_reg <= entry_next.payload;
        ttl_reg     <= entry_next.ttl;
    end

    assign q.valid   = valid_reg;
    assign q.address = address_reg;
    assign q.payload = payload_reg;
    assign q.ttl     = ttl_reg;

endmodule

[hw/rtl/ptta_ctrl.sv]
// ----------------------------------------------------------------------------
// ptta_ctrl
// Walk sequencer at the head of the cell ring: search, aging, read capture,
// write-back and result register.
// ----------------------------------------------------------------------------
module ptta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ptta_pkg::req_t      req,
    output logic                rsp_valid,
    output ptta_pkg::rsp_t      rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    input  ptta_pkg::entry_t    head,
    output ptta_pkg::entry_t    head_new,
    output ptta_pkg::entry_t    wr_data,
    output ptta_pkg::ring_ctl_t ctl
);
    import ptta_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_WRITE} state_t;

    state_t             state_reg;
    req_t               op_reg;
    logic [SLOT_W-1:0]  cnt_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_slot_reg;
    logic               free_reg;
    logic [SLOT_W-1:0]  free_slot_reg;
    logic [FREED_W-1:0] freed_reg;
    entry_t             rd_reg;
    logic [SLOT_W-1:0]  tgt_reg;
    logic [7:0]         ttl_reload_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic               hit_next;
    logic [SLOT_W-1:0]  hit_slot_next;
    logic               free_next;
    logic [SLOT_W-1:0]  free_slot_next;
    logic [FREED_W-1:0] freed_next;
    entry_t             rd_next;
    logic               rsp_valid_next;
    rsp_t               rsp_next;
    logic [7:0]         ttl_dec;
    logic               last;

    assign last    = (cnt_reg == SLOT_W'(PEER_SLOTS - 1));
    assign ttl_dec = head.ttl - 8'd1;

    always_comb
    begin
        head_new = head;
        if (op_reg.func == FUNC_TICK && head.valid)
        begin
            if (ttl_dec == 8'd0)
            begin
                head_new = '0;
            end
            else
            begin
                head_new.ttl = ttl_dec;
            end
        end
    end

    always_comb
    begin
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        freed_next     = freed_reg;
        rd_next        = rd_reg;
        if (head.valid)
        begin
            if (!hit_reg && head.address == op_reg.peer_address)
            begin
                hit_next      = 1'b1;
                hit_slot_next = cnt_reg;
            end
            if (ttl_dec == 8'd0)
            begin
                freed_next = freed_reg + FREED_W'(1);
            end
        end
        else if (!free_reg)
        begin
            free_next      = 1'b1;
            free_slot_next = cnt_reg;
        end
        if (32'(op_reg.read_slot) == 32'(cnt_reg))
        begin
            rd_next = head;
        end
    end

    always_comb
    begin
        rsp_valid_next = 1'b0;
        if (state_reg == S_WRITE)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (state_reg == S_WALK && last)
        begin
            rsp_valid_next = !(op_reg.func == FUNC_ADD && (hit_next || free_next));
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (state_reg == S_WRITE)
        begin
            rsp_next.status    = hit_reg ? ST_REFRESHED : ST_INSERTED;
            rsp_next.slot_used = 9'(tgt_reg);
        end
        else
        begin
            case (op_reg.func)
                FUNC_ADD:
                begin
                    rsp_next.status = ST_DROPPED;
                end
                FUNC_TICK:
                begin
                    rsp_next.status        = ST_AGED;
                    rsp_next.expired_count = 10'(freed_next);
                end
                default:
                begin
                    rsp_next.status        = ST_READ;
                    rsp_next.slot_used     = op_reg.read_slot;
                    rsp_next.entry_valid   = rd_next.valid;
                    rsp_next.entry_address = rd_next.address;
                    rsp_next.entry_payload = 64'(rd_next.payload);
                    rsp_next.entry_ttl     = rd_next.ttl;
                end
            endcase
        end
    end

    always_comb
    begin
        wr_data.valid   = 1'b1;
        wr_data.address = op_reg.peer_address;
        wr_data.payload = op_reg.peer_payload[PAYLOAD_BITS-1:0];
        wr_data.ttl     = (ttl_reload_reg == 8'd0) ? 8'd1 : ttl_reload_reg;
    end

    assign ctl.shift_en = (state_reg == S_WALK);
    assign ctl.wr_en    = (state_reg == S_WRITE);
    assign ctl.wr_slot  = tgt_reg;
    assign busy         = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            free_reg       <= 1'b0;
            free_slot_reg  <= '0;
            freed_reg      <= '0;
            rd_reg         <= '0;
            tgt_reg        <= '0;
            ttl_reload_reg <= 8'd60;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (rsp_valid_next)
            begin
                rsp_reg <= rsp_next;
            end
            if (cfg_valid)
            begin
                ttl_reload_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start && req.func != FUNC_NOP)
                    begin
                        op_reg    <= req;
                        cnt_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        freed_reg <= '0;
                        rd_reg    <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    cnt_reg       <= cnt_reg + SLOT_W'(1);
                    hit_reg       <= hit_next;
                    hit_slot_reg  <= hit_slot_next;
                    free_reg      <= free_next;
                    free_slot_reg <= free_slot_next;
                    freed_reg     <= freed_next;
                    rd_reg        <= rd_next;
                    if (last)
                    begin
                        if (op_reg.func == FUNC_ADD && (hit_next || free_next))
                        begin
                            tgt_reg   <= hit_next ? hit_slot_next : free_slot_next;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_WRITE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |=> !rsp_valid)
        else $error("back-to-back result strobes");
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !busy)
        else $error("result strobe while busy");
    a_write_add: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (op_reg.func == FUNC_ADD && (hit_reg || free_reg)))
        else $error("table write outside an add transaction");
`endif

endmodule

[hw/rtl/peer_table_with_ttl_aging.sv]
// ----------------------------------------------------------------------------
// peer_table_with_ttl_aging
// Peer table with time-to-live aging, built as a ring of entry cells.
// ----------------------------------------------------------------------------
// Every transaction rotates the whole ring once.
// An add that finds a hit or a free slot then writes that slot; the result strobe follows.
// A new transaction is taken only while busy is low, once the previous one is done.
// Reset: all entries invalid, ttl_reload 60; no clearing pass.
module peer_table_with_ttl_aging (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ptta_pkg::req_t   req,
    output logic             rsp_valid,
    output ptta_pkg::rsp_t   rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data
);
    import ptta_pkg::*;

    entry_t    ring_q [PEER_SLOTS];
    entry_t    head_new;
    entry_t    wr_data;
    ring_ctl_t ctl;

    ptta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .head      (ring_q[0]),
        .head_new  (head_new),
        .wr_data   (wr_data),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < PEER_SLOTS; i++)
    begin : g_cell
        entry_t shift_in;
        if (i == PEER_SLOTS - 1)
        begin : g_tail
            assign shift_in = head_new;
        end
        else
        begin : g_body
            assign shift_in = ring_q[i+1];
        end

        ptta_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (ctl.shift_en),
            .wr_en    (ctl.wr_en && ctl.wr_slot == SLOT_W'(i)),
            .shift_in (shift_in),
            .wr_data  (wr_data),
            .q        (ring_q[i])
        );
    end

endmodule

[verif/peer_table_with_ttl_aging_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_table_with_ttl_aging_checker
// Watches the request, response and config channels of the peer table,
// keeps a shadow copy of the table and compares every response in order.
// ----------------------------------------------------------------------------
module peer_table_with_ttl_aging_checker
    import ptta_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  logic   busy,
    input  req_t   req,
    input  logic   rsp_valid,
    input  rsp_t   rsp,
    input  logic   cfg_valid,
    input  logic   cfg_ready,
    input  logic [7:0] cfg_data,
    output int     fail_count,
    output int     pending_count
);

    logic [7:0]  shadow_reload;
    entry_t      shadow_table [PEER_SLOTS];
    rsp_t        expected_rsps [$];

    function automatic rsp_t apply_request(req_t r);
        rsp_t o;
        bit   hit;
        bit   have_free;
        int   free_slot;
        int   target;
        int   freed;
        o = '0;
        hit = 0;
        have_free = 0;
        free_slot = 0;
        target = 0;
        freed = 0;
        case (r.func)
            FUNC_ADD:
            begin
                for (int i = 0; i < PEER_SLOTS; i++)
                begin
                    if (shadow_table[i].valid)
                    begin
                        if (!hit && shadow_table[i].address == r.peer_address)
                        begin
                            hit = 1;
                            target = i;
                        end
                    end
                    else if (!have_free)
                    begin
                        have_free = 1;
                        free_slot = i;
                    end
                end
                if (!hit && !have_free)
                    o.status = ST_DROPPED;
                else
                begin
                    if (!hit)
                        target = free_slot;
                    shadow_table[target].valid   = 1'b1;
                    shadow_table[target].address = r.peer_address;
                    shadow_table[target].payload = r.peer_payload;
                    shadow_table[target].ttl     = (shadow_reload == 0) ? 8'd1 : shadow_reload;
                    o.status    = hit ? ST_REFRESHED : ST_INSERTED;
                    o.slot_used = target[8:0];
                end
            end
            FUNC_TICK:
            begin
                for (int i = 0; i < PEER_SLOTS; i++)
                begin
                    if (shadow_table[i].valid)
                    begin
                        shadow_table[i].ttl = shadow_table[i].ttl - 8'd1;
                        if (shadow_table[i].ttl == 0)
                        begin
                            shadow_table[i] = '0;
                            freed++;
                        end
                    end
                end
                o.status = ST_AGED;
                o.expired_count = freed[9:0];
            end
            default:
            begin
                o.status = ST_READ;
                o.slot_used = r.read_slot;
                if (r.read_slot < PEER_SLOTS)
                begin
                    o.entry_valid   = shadow_table[r.read_slot].valid;
                    o.entry_address = shadow_table[r.read_slot].address;
                    o.entry_payload = shadow_table[r.read_slot].payload;
                    o.entry_ttl     = shadow_table[r.read_slot].ttl;
                end
            end
        endcase
        return o;
    endfunction

    assign pending_count = expected_rsps.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            shadow_reload <= 8'd60;
            for (int i = 0; i < PEER_SLOTS; i++)
                shadow_table[i] = '0;
            expected_rsps.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shadow_reload <= cfg_data;
            if (rsp_valid)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp !== want)
                    begin
                        $display("%0t: response mismatch, expected %h, actual %h",
                                 $time, want, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy && req.func != FUNC_NOP)
                expected_rsps.push_back(apply_request(req));
        end
    end

endmodule

[verif/tb_peer_table_with_ttl_aging.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peer_table_with_ttl_aging
// Drives add, tick, read and no-op transactions and ttl reload writes into the peer
// table; the checker predicts each response and counts mismatches.
// ----------------------------------------------------------------------------
module tb_peer_table_with_ttl_aging;
    import ptta_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       rsp_valid;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending_count;
    int         gap_pct;
    logic [31:0] addr_pool [8];

    peer_table_with_ttl_aging i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    peer_table_with_ttl_aging_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp           (rsp),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #40ms;
        $display("tb_peer_table_with_ttl_aging: FAIL");
        $finish;
    end

    task automatic send_req(logic [1:0] f, logic [31:0] a, logic [63:0] p, logic [8:0] s);
        while ($urandom_range(99, 0) < gap_pct)
            @(posedge clk);
        start <= 1'b1;
        req   <= '{func: f, peer_address: a, peer_payload: p, read_slot: s};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        req   <= '0;
        @(posedge clk);
    endtask

    task automatic write_reload(logic [7:0] v);
        while (pending_count != 0)
            @(posedge clk);
        repeat (520) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_peer(logic [31:0] a);
        send_req(FUNC_ADD, a, {$urandom, $urandom}, 9'($urandom));
    endtask

    initial
    begin
        logic [1:0] f;
        int         fill;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        gap_pct   = 0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(FUNC_TICK, '0, '0, '0);
        send_req(FUNC_ADD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 9'h1FF);
        send_req(FUNC_ADD, 32'h0, 64'h0, 9'h0);
        send_req(FUNC_ADD, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA, 9'h0);
        send_req(FUNC_READ, '0, '0, 9'd0);
        send_req(FUNC_READ, '0, '0, 9'd1);
        send_req(FUNC_NOP, 32'h1234, 64'h1, 9'd3);
        send_req(FUNC_TICK, '0, '0, '0);
        send_req(FUNC_READ, '0, '0, 9'd0);

        write_reload(8'd0);
        send_req(FUNC_ADD, 32'hA5A5_0001, 64'hAAAA_5555_AAAA_5555, 9'd0);
        send_req(FUNC_READ, '0, '0, 9'd2);
        send_req(FUNC_TICK, '0, '0, '0);
        send_req(FUNC_READ, '0, '0, 9'd0);

        write_reload(8'd255);
        for (fill = 0; fill < PEER_SLOTS; fill++)
            send_req(FUNC_ADD, 32'h1000_0000 + fill, {$urandom, $urandom}, '0);
        send_req(FUNC_ADD, 32'hDEAD_BEEF, 64'h1, '0);
        send_req(FUNC_ADD, 32'h1000_0005, 64'h2, '0);
        send_req(FUNC_READ, '0, '0, 9'd511);
        write_reload(8'd1);
        send_req(FUNC_ADD, 32'h1000_0007, 64'h3, '0);
        send_req(FUNC_TICK, '0, '0, '0);
        write_reload(8'd2);
        for (fill = 0; fill < 3; fill++)
            send_req(FUNC_TICK, '0, '0, '0);

        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 15 : ((ph == 1) ? 70 : 0);
            write_reload(ph == 0 ? 8'd3 : (ph == 1 ? 8'($urandom_range(255, 1)) : 8'd5));
            for (int k = 0; k < 8; k++)
                addr_pool[k] = $urandom;
            for (int n = 0; n < 200; n++)
            begin
                f = 2'($urandom_range(99, 0) < 55 ? FUNC_ADD
                      : ($urandom_range(1, 0) ? FUNC_TICK : FUNC_READ));
                if ($urandom_range(99, 0) < 3)
                    f = FUNC_NOP;
                if (f == FUNC_ADD)
                    send_req(f, $urandom_range(3, 0) == 0 ? $urandom
                                 : addr_pool[$urandom_range(7, 0)],
                             {$urandom, $urandom}, 9'($urandom));
                else if (f == FUNC_READ)
                    send_req(f, $urandom, {$urandom, $urandom},
                             9'($urandom_range(99, 0) < 80 ? $urandom_range(15, 0)
                                                           : $urandom));
                else
                    send_req(f, $urandom, {$urandom, $urandom}, 9'($urandom));
            end
        end

        while (pending_count != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("tb_peer_table_with_ttl_aging: PASS");
        else
            $display("tb_peer_table_with_ttl_aging: FAIL");
        $finish;
    end

endmodule
